@@ hw/rtl/dcc_bit_and_packet_decoder_macros.svh @@
// Assertion helpers used by the decoder framer.
`ifndef DCC_BIT_AND_PACKET_DECODER_MACROS_SVH
`define DCC_BIT_AND_PACKET_DECODER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define DCCD_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a trigger implies a consequence at the same edge.
`define DCCD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a trigger implies a consequence at the next edge.
`define DCCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dccd_pkg.sv @@
`default_nettype none

package dccd_pkg;

    typedef struct packed {
        logic        edge_rising;
        logic [31:0] edge_time;
    } edge_item_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] one_min_len;
        logic [15:0] one_max_len;
        logic [15:0] zero_min_len;
        logic [15:0] zero_max_len;
        logic [4:0]  preamble_min;
        logic [4:0]  preamble_max;
    } cfg_t;

    typedef enum logic {
        ST_SEARCH,
        ST_DATA
    } framer_state_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ONE_MIN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_MAX  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_MIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_MAX = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PRE_MIN  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PRE_MAX  = 3'd5;

    localparam logic [15:0] RST_ONE_MIN  = 16'd52;
    localparam logic [15:0] RST_ONE_MAX  = 16'd64;
    localparam logic [15:0] RST_ZERO_MIN = 16'd90;
    localparam logic [15:0] RST_ZERO_MAX = 16'd10000;
    localparam logic [4:0]  RST_PRE_MIN  = 5'd10;
    localparam logic [4:0]  RST_PRE_MAX  = 5'd12;

    localparam logic [3:0] BYTE_BITS    = 4'd8;
    localparam logic [4:0] PREAMBLE_SAT = 5'd31;

endpackage

`default_nettype wire

@@ hw/rtl/dccd_fifo.sv @@
`default_nettype none

module dccd_fifo #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dccd_front.sv @@
`default_nettype none

module dccd_front
    import dccd_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       push,
    input  wire edge_item_t edge_item,
    output logic            full,
    output logic            bit_push,
    output logic            bit_value,
    input  wire logic       bit_full
);

    logic [TIME_BITS-1:0] rise_time_reg, rise_time_next;
    logic                 rise_seen_reg, rise_seen_next;
    logic [TIME_BITS-1:0] time_now;
    logic [TIME_BITS-1:0] high_len;
    logic                 accept;
    logic                 is_one, is_zero;

    assign full     = bit_full;
    assign accept   = push && !bit_full;
    assign time_now = TIME_BITS'(edge_item.edge_time);
    assign high_len = time_now - rise_time_reg;

    assign is_one  = (high_len >= TIME_BITS'(cfg.one_min_len))
                  && (high_len <= TIME_BITS'(cfg.one_max_len));
    assign is_zero = (high_len >= TIME_BITS'(cfg.zero_min_len))
                  && (high_len <= TIME_BITS'(cfg.zero_max_len));

    // One window wins when both match.
    assign bit_value = is_one;
    assign bit_push  = accept && !edge_item.edge_rising && rise_seen_reg && (is_one || is_zero);

    always_comb
    begin
        rise_time_next = rise_time_reg;
        rise_seen_next = rise_seen_reg;
        if (accept && edge_item.edge_rising)
        begin
            rise_time_next = time_now;
            rise_seen_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_time_reg <= '0;
            rise_seen_reg <= 1'b0;
        end
        else
        begin
            rise_time_reg <= rise_time_next;
            rise_seen_reg <= rise_seen_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dccd_framer.sv @@
`default_nettype none
`include "dcc_bit_and_packet_decoder_macros.svh"

module dccd_framer
    import dccd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  bit_valid,
    input  wire logic  bit_value,
    output logic       bit_take,
    output logic       out_push,
    output byte_item_t out_item,
    input  wire logic  out_full
);

    framer_state_t state_reg, state_next;
    logic [4:0]    preamble_reg, preamble_next;
    logic [3:0]    bits_reg, bits_next;
    logic [7:0]    shift_reg, shift_next;
    logic          pre_ok;
    logic          byte_done;

    assign bit_take  = bit_valid && !out_full;
    assign pre_ok    = (preamble_reg >= cfg.preamble_min) && (preamble_reg <= cfg.preamble_max);
    assign byte_done = (state_reg == ST_DATA) && (bits_reg == BYTE_BITS);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (bit_take)
        begin
            unique case (state_reg)
                ST_SEARCH:
                begin
                    if (!bit_value && pre_ok)
                    begin
                        state_next = ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    if (byte_done && bit_value)
                    begin
                        state_next = ST_SEARCH;
                    end
                end
                default: state_next = ST_SEARCH;
            endcase
        end
    end

    // Datapath and outputs.
    always_comb
    begin
        preamble_next        = preamble_reg;
        bits_next            = bits_reg;
        shift_next           = shift_reg;
        out_push             = 1'b0;
        out_item.packet_byte = shift_reg;
        out_item.last_byte   = bit_value;
        if (bit_take)
        begin
            unique case (state_reg)
                ST_SEARCH:
                begin
                    if (bit_value)
                    begin
                        if (preamble_reg != PREAMBLE_SAT)
                        begin
                            preamble_next = preamble_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        preamble_next = '0;
                        bits_next     = '0;
                        shift_next    = '0;
                    end
                end
                ST_DATA:
                begin
                    if (byte_done)
                    begin
                        out_push      = 1'b1;
                        bits_next     = '0;
                        shift_next    = '0;
                        preamble_next = '0;
                    end
                    else
                    begin
                        shift_next = {shift_reg[6:0], bit_value};
                        bits_next  = bits_reg + 4'd1;
                    end
                end
                default:
                begin
                    preamble_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SEARCH;
            preamble_reg <= '0;
            bits_reg     <= '0;
            shift_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            preamble_reg <= preamble_next;
            bits_reg     <= bits_next;
            shift_reg    <= shift_next;
        end
    end

    `DCCD_ASSERT_IMPL(a_search_no_bits, state_reg == ST_SEARCH, bits_reg == '0, "bit count not clear in search")
    `DCCD_ASSERT_IMPL(a_push_full_byte, out_push, byte_done && !out_full, "byte emitted before eight bits")
    `DCCD_ASSERT_NEXT(a_last_to_search, out_push && out_item.last_byte, state_reg == ST_SEARCH, "no return to search after last byte")

endmodule

`default_nettype wire

@@ hw/rtl/dcc_bit_and_packet_decoder.sv @@
`default_nettype none

// DCC track decoder: push one track edge per request (edge_rising plus a free-running
// microsecond edge_time) and pop decoded packet bytes, each flagged last_byte when the
// separator after it was a one. A rising edge stores its time; a falling edge measures
// the high time modulo 2^TIME_BITS and becomes a one or zero bit through the
// one_*_len / zero_*_len windows (one wins on overlap, other lengths are dropped).
// A front stage classifies edges into a small bit queue; a framer hunts for
// preamble_min..preamble_max ones followed by a zero, then packs eight bits MSB first
// plus a separator per byte into the result queue. One edge is taken per clock while
// the bit queue has room; the framer drains one bit per clock while the result queue
// has room, so a full result queue backs up into the bit queue and then stalls the
// input. With both queues flowing, the bit that completes a byte is written to the bit
// queue, and the byte then to the result queue, before it shows at the result ports.
// Write config registers (index 0..5: one_min, one_max, zero_min, zero_max,
// preamble_min, preamble_max) only when idle; unknown indexes are dropped.
module dcc_bit_and_packet_decoder
    import dccd_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32,
    parameter int unsigned BIT_DEPTH = 2,
    parameter int unsigned OUT_DEPTH = 2
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   push,
    input  wire edge_item_t             edge_item,
    output logic                        full,
    input  wire logic                   pop,
    output byte_item_t                  byte_item,
    output logic                        empty
);

    cfg_t       cfg_reg, cfg_next;
    logic       bit_push, bit_value, bit_full;
    logic       bit_empty, bit_head, bit_take;
    logic       out_push, out_full;
    byte_item_t out_item;

    // Register bank: mask each value to its register width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ONE_MIN:  cfg_next.one_min_len  = cfg_data;
                REG_ONE_MAX:  cfg_next.one_max_len  = cfg_data;
                REG_ZERO_MIN: cfg_next.zero_min_len = cfg_data;
                REG_ZERO_MAX: cfg_next.zero_max_len = cfg_data;
                REG_PRE_MIN:  cfg_next.preamble_min = cfg_data[4:0];
                REG_PRE_MAX:  cfg_next.preamble_max = cfg_data[4:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_min_len  <= RST_ONE_MIN;
            cfg_reg.one_max_len  <= RST_ONE_MAX;
            cfg_reg.zero_min_len <= RST_ZERO_MIN;
            cfg_reg.zero_max_len <= RST_ZERO_MAX;
            cfg_reg.preamble_min <= RST_PRE_MIN;
            cfg_reg.preamble_max <= RST_PRE_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify edges into bits.
    dccd_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .edge_item (edge_item),
        .full      (full),
        .bit_push  (bit_push),
        .bit_value (bit_value),
        .bit_full  (bit_full)
    );

    // Decouple classifier from framer.
    dccd_fifo #(
        .WIDTH (1),
        .DEPTH (BIT_DEPTH)
    ) u_bit_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (bit_push),
        .wr_data (bit_value),
        .full    (bit_full),
        .pop     (bit_take),
        .rd_data (bit_head),
        .empty   (bit_empty)
    );

    // Frame bits into bytes.
    dccd_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .bit_valid (!bit_empty),
        .bit_value (bit_head),
        .bit_take  (bit_take),
        .out_push  (out_push),
        .out_item  (out_item),
        .out_full  (out_full)
    );

    // Hold finished bytes until popped.
    dccd_fifo #(
        .WIDTH ($bits(byte_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (out_item),
        .full    (out_full),
        .pop     (pop),
        .rd_data (byte_item),
        .empty   (empty)
    );

endmodule

`default_nettype wire
